// ===== src/trajectory_knot_interpolator_macros.svh =====
// Assertion macros shared by the knot interpolator RTL.
`ifndef TRAJECTORY_KNOT_INTERPOLATOR_MACROS_SVH
`define TRAJECTORY_KNOT_INTERPOLATOR_MACROS_SVH
// Implication checked on every clock edge, off during reset.
`define TKI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define TKI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== src/tki_pkg.sv =====
// Shared types and constants of the trajectory knot interpolator.
package tki_pkg;
    localparam int unsigned TimeW = 32;
    localparam int unsigned PosW  = 32;
    localparam int unsigned DigW  = 2;

    localparam logic [1:0] StOk       = 2'd0;
    localparam logic [1:0] StNoKnots  = 2'd1;
    localparam logic [1:0] StOverflow = 2'd2;

    localparam logic OpLoad  = 1'b0;
    localparam logic OpQuery = 1'b1;

    localparam logic CfgStart = 1'b0;
    localparam logic CfgEnd   = 1'b1;

    // Divider request: magnitude-times-dt dividend and divisor.
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic        busy;
        logic [31:0] quotient;
    } div_rsp_t;
endpackage

// ===== src/tki_serial_mult.sv =====
// Digit-serial unsigned multiplier, 32 by 32, two multiplier bits a cycle.
module tki_serial_mult
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        done,
    output logic [63:0] product
);
    logic [63:0] acc_reg, acc_next;
    logic [31:0] mcand_reg, mcand_next;
    logic [31:0] mplier_reg, mplier_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [33:0] pp;

    // one radix-4 digit: partial product of the low two multiplier bits
    always_comb
    begin
        pp = ({2'b00, mcand_reg} & {34{mplier_reg[0]}})
           + ({1'b0, mcand_reg, 1'b0} & {34{mplier_reg[1]}});
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start)
        begin
            acc_next    = '0;
            mcand_next  = a;
            mplier_next = b;
            cnt_next    = '0;
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            // add at the top, shift right two bits
            acc_next    = {({2'b00, acc_reg[63:32]} + pp), acc_reg[31:2]};
            mplier_next = {2'b00, mplier_reg[31:2]};
            cnt_next    = cnt_reg + 5'd1;
            if (cnt_reg == 5'd15)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;
endmodule

// ===== src/tki_serial_div.sv =====
// Bit-serial restoring divider: 64-bit dividend by 32-bit divisor, one bit a cycle.
module tki_serial_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  tki_pkg::div_req_t req,
    output tki_pkg::div_rsp_t rsp
);
    logic [63:0] num_reg, num_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [33:0] trial;
    logic [32:0] shifted;

    // quotient bits shift into num_reg; quotient fits 32 bits since dt < dur
    always_comb
    begin
        shifted   = {rem_reg[31:0], num_reg[63]};
        trial     = {1'b0, shifted} - {2'b00, den_reg};
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            num_next  = req.dividend;
            rem_next  = '0;
            den_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial[33])
            begin
                rem_next = shifted;
                num_next = {num_reg[62:0], 1'b0};
            end
            else
            begin
                rem_next = trial[32:0];
                num_next = {num_reg[62:0], 1'b1};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.busy     = busy_reg;
    assign rsp.quotient = num_reg[31:0];
endmodule

// ===== src/tki_lerp.sv =====
// One-axis interpolation: |p1-p0| * dt serially, then serial divide by dur.
module tki_lerp
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] p0,
    input  logic [31:0] p1,
    input  logic [31:0] dt,
    input  logic [31:0] dur,
    output logic        done,
    output logic [31:0] result
);
    `include "trajectory_knot_interpolator_macros.svh"

    logic [32:0] diff;
    logic        neg_reg;
    logic [32:0] mag;
    logic [31:0] p0_reg;
    logic [31:0] dur_reg;
    logic        mul_done;
    logic [63:0] product;
    tki_pkg::div_req_t dreq;
    tki_pkg::div_rsp_t drsp;

    // difference in 33 bits; magnitude at most 2^32-1 fits 32 bits
    always_comb
    begin
        diff = {p1[31], p1} - {p0[31], p0};
        mag  = diff[32] ? (~diff + 33'd1) : diff;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= diff[32];
            p0_reg  <= p0;
            dur_reg <= dur;
        end
    end

    tki_serial_mult u_mult
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .a       (mag[31:0]),
        .b       (dt),
        .done    (mul_done),
        .product (product)
    );

    assign dreq.start    = mul_done;
    assign dreq.dividend = product;
    assign dreq.divisor  = dur_reg;

    tki_serial_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign done   = drsp.done;
    assign result = neg_reg ? (p0_reg - drsp.quotient) : (p0_reg + drsp.quotient);

    `TKI_ASSERT_NEXT(a_div_follows_mult, clk, rst_n, mul_done, drsp.busy,
        "divider did not start after multiply")
    `TKI_ASSERT_IMPL(a_no_restart, clk, rst_n, drsp.busy, !mul_done,
        "multiply finished while divider busy")
    `TKI_ASSERT_IMPL(a_done_not_busy, clk, rst_n, drsp.done, !drsp.busy,
        "divider done while still busy")
endmodule

// ===== src/trajectory_knot_interpolator.sv =====
// Top level of the trajectory knot interpolator: knot store, control sequencer.
//
//   channel  | dir | payload
//   s_axis   | in  | tdata {vel_y,vel_x,pos_y,pos_x,sample_time}, tuser {first,opcode}, tlast last
//   m_axis   | out | tdata {pad,status,out_y,out_x}
//   cfg      | in  | wr_en, wr_index, wr_data
//
// A load is handled in S_IDLE (one knot write at most, one memory port); the next item is
// taken on the following cycle.
// A query on an end knot posts its result after S_QREAD0 and S_QCHK0 (first knot) or after
// those and S_QREADL, S_QCHKL (last knot). An interpolating query runs the 4 end checks, S_SCAN
// and S_SCANCHK per knot walked, S_LSTART to launch, the 16-step serial multiply and the
// 64-step serial divide with hand-offs in S_LRUN, and S_OUT to post.
// Knot memories have no reset; the count marks what is valid.
// A result waiting in the output register stalls only the next query's post step.
module trajectory_knot_interpolator
#(
    parameter int unsigned MAX_KNOTS = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [159:0] s_axis_tdata,  // sample_time, pos_x, pos_y, vel_x, vel_y
    input  logic [1:0]   s_axis_tuser,  // opcode, first_sample
    input  logic         s_axis_tlast,  // last_sample
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata,  // out_x, out_y, status, pad
    input  logic         wr_en,
    input  logic         wr_index,
    input  logic [31:0]  wr_data
);
    `include "trajectory_knot_interpolator_macros.svh"

    localparam int unsigned AW = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
    localparam int unsigned CW = $clog2(MAX_KNOTS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_QREAD0, S_QCHK0, S_QREADL, S_QCHKL, S_SCAN, S_SCANCHK,
        S_LSTART, S_LRUN, S_OUT
    } state_t;

    state_t state_reg;

    logic [31:0] start_reg, end_reg;

    // knot memories
    logic [31:0] mem_t [MAX_KNOTS];
    logic [31:0] mem_x [MAX_KNOTS];
    logic [31:0] mem_y [MAX_KNOTS];
    logic [AW-1:0] rd_addr;
    logic [31:0] rd_t, rd_x, rd_y;

    logic [CW-1:0] count_reg;
    logic          ovf_reg;
    logic          run_reg, pend_reg;
    logic [31:0]   prev_t_reg, prev_x_reg, prev_y_reg, prev_vx_reg, prev_vy_reg;
    logic [31:0]   last_t_reg;

    // captured query time
    logic [31:0] t_reg;

    logic [AW-1:0] idx_reg;
    logic [31:0]   t0_reg, x0_reg, y0_reg;
    logic          lerp_go_reg;
    logic [31:0]   ox_reg, oy_reg;
    logic [1:0]    st_reg;
    logic          ovalid_reg;
    logic [31:0]   out_x_reg, out_y_reg;
    logic [1:0]    out_st_reg;
    logic          xdone, ydone;
    logic [31:0]   xres, yres;

    logic        in_op, in_first, in_last;
    logic [31:0] in_t, in_px, in_py, in_vx, in_vy;
    logic        acc;

    // knot write decision for one put (time t, count, newest time)
    logic          wr_go;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_t, wr_x, wr_y;
    logic [CW-1:0] cnt_after;
    logic          ovf_set;
    logic [31:0]   last_after;
    logic          do_put;
    logic [CW-1:0] cnt_base;
    logic          mid_bounce;

    assign in_op    = s_axis_tuser[0];
    assign in_first = s_axis_tuser[1];
    assign in_last  = s_axis_tlast;
    assign in_t     = s_axis_tdata[31:0];
    assign in_px    = s_axis_tdata[63:32];
    assign in_py    = s_axis_tdata[95:64];
    assign in_vx    = s_axis_tdata[127:96];
    assign in_vy    = s_axis_tdata[159:128];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign acc = s_axis_tvalid && s_axis_tready;

    function automatic logic [AW-1:0] to_addr(input logic [CW-1:0] c);
        logic [CW:0] w;
        w = {1'b0, c};
        return w[AW-1:0];
    endfunction

    // puts: first sample or last sample (one put), mid sample (pend or bounce put;
    // a second put of the same knot would only rewrite it with the same values)
    always_comb
    begin
        mid_bounce = (in_vx != prev_vx_reg) || (in_vy != prev_vy_reg);
        do_put   = 1'b0;
        wr_t     = prev_t_reg;
        wr_x     = prev_x_reg;
        wr_y     = prev_y_reg;
        cnt_base = count_reg;
        if (acc && in_op == tki_pkg::OpLoad && !(in_first && in_last))
        begin
            if (in_first)
            begin
                do_put = 1'b1; cnt_base = '0;
                wr_t = in_t; wr_x = in_px; wr_y = in_py;
            end
            else if (run_reg && in_last)
            begin
                do_put = 1'b1;
                wr_t = in_t; wr_x = in_px; wr_y = in_py;
            end
            else if (run_reg)
                do_put = pend_reg || mid_bounce;
        end
        wr_go      = 1'b0;
        wr_addr    = to_addr(cnt_base);
        cnt_after  = cnt_base;
        ovf_set    = 1'b0;
        last_after = last_t_reg;
        if (do_put)
        begin
            if (cnt_base != '0 && wr_t == last_t_reg)
            begin
                wr_go = 1'b1; wr_addr = to_addr(cnt_base - 1'b1);
            end
            else if (cnt_base != '0 && wr_t < last_t_reg)
                wr_go = 1'b0;
            else if (cnt_base >= CW'(MAX_KNOTS))
                ovf_set = 1'b1;
            else
            begin
                wr_go = 1'b1; cnt_after = cnt_base + 1'b1; last_after = wr_t;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_go)
        begin
            mem_t[wr_addr] <= wr_t;
            mem_x[wr_addr] <= wr_x;
            mem_y[wr_addr] <= wr_y;
        end
        rd_t <= mem_t[rd_addr];
        rd_x <= mem_x[rd_addr];
        rd_y <= mem_y[rd_addr];
    end

    // read address per state
    always_comb
    begin
        case (state_reg)
            S_QREADL:  rd_addr = to_addr(count_reg - 1'b1);
            S_SCAN:    rd_addr = idx_reg;
            S_SCANCHK: rd_addr = idx_reg;
            S_LSTART:  rd_addr = idx_reg;
            default:   rd_addr = '0;
        endcase
    end

    tki_lerp u_lerp_x
    (
        .clk (clk), .rst_n (rst_n), .start (lerp_go_reg),
        .p0 (x0_reg), .p1 (rd_x), .dt (t_reg - t0_reg), .dur (rd_t - t0_reg),
        .done (xdone), .result (xres)
    );
    tki_lerp u_lerp_y
    (
        .clk (clk), .rst_n (rst_n), .start (lerp_go_reg),
        .p0 (y0_reg), .p1 (rd_y), .dt (t_reg - t0_reg), .dur (rd_t - t0_reg),
        .done (ydone), .result (yres)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            start_reg   <= '0;
            end_reg     <= '0;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            run_reg     <= 1'b0;
            pend_reg    <= 1'b0;
            prev_t_reg  <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            prev_vx_reg <= '0;
            prev_vy_reg <= '0;
            last_t_reg  <= '0;
            t_reg       <= '0;
            t0_reg      <= '0;
            x0_reg      <= '0;
            y0_reg      <= '0;
            ox_reg      <= '0;
            oy_reg      <= '0;
            st_reg      <= tki_pkg::StOk;
            out_x_reg   <= '0;
            out_y_reg   <= '0;
            out_st_reg  <= tki_pkg::StOk;
            lerp_go_reg <= 1'b0;
            ovalid_reg  <= 1'b0;
            idx_reg     <= '0;
        end
        else
        begin
            lerp_go_reg <= (state_reg == S_LSTART);
            if (wr_en)
            begin
                if (wr_index == tki_pkg::CfgStart) start_reg <= wr_data;
                else                                end_reg   <= wr_data;
            end
            // output register: take a finished query, or empty on transfer
            if (state_reg == S_OUT && (!ovalid_reg || m_axis_tready))
            begin
                ovalid_reg <= 1'b1;
                out_x_reg  <= ox_reg;
                out_y_reg  <= oy_reg;
                out_st_reg <= st_reg;
            end
            else if (m_axis_tready)
                ovalid_reg <= 1'b0;
            if (do_put)
            begin
                count_reg  <= cnt_after;
                last_t_reg <= last_after;
                if (ovf_set) ovf_reg <= 1'b1;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (acc)
                    begin
                        t_reg <= in_t;
                        if (in_op == tki_pkg::OpQuery)
                            state_reg <= S_QREAD0;
                        else if (!(in_first && in_last) && (in_first || run_reg))
                        begin
                            if (in_first)
                            begin
                                if (!ovf_set) ovf_reg <= 1'b0;
                                run_reg <= 1'b1; pend_reg <= 1'b0;
                            end
                            else if (in_last)
                            begin
                                run_reg <= 1'b0; pend_reg <= 1'b0;
                            end
                            else
                                pend_reg <= mid_bounce;
                            prev_t_reg  <= in_t;
                            prev_x_reg  <= in_px;
                            prev_y_reg  <= in_py;
                            prev_vx_reg <= in_vx;
                            prev_vy_reg <= in_vy;
                        end
                    end
                end
                S_QREAD0: state_reg <= S_QCHK0;
                S_QCHK0:
                begin
                    st_reg <= (count_reg == '0) ? tki_pkg::StNoKnots :
                              (ovf_reg ? tki_pkg::StOverflow : tki_pkg::StOk);
                    // knot 0 is the lower bracket if the walk stops at once
                    t0_reg <= rd_t; x0_reg <= rd_x; y0_reg <= rd_y;
                    if (count_reg == '0)
                    begin
                        ox_reg <= '0; oy_reg <= '0;
                        state_reg <= S_OUT;
                    end
                    else if (t_reg <= start_reg || t_reg < rd_t)
                    begin
                        ox_reg <= rd_x; oy_reg <= rd_y; state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_QREADL;
                end
                S_QREADL: state_reg <= S_QCHKL;
                S_QCHKL:
                begin
                    if (t_reg >= end_reg || t_reg >= rd_t)
                    begin
                        ox_reg <= rd_x; oy_reg <= rd_y; state_reg <= S_OUT;
                    end
                    else
                    begin
                        idx_reg <= AW'(1); state_reg <= S_SCAN;
                    end
                end
                S_SCAN: state_reg <= S_SCANCHK;
                // linear walk to the first knot later than t; keep the one before
                S_SCANCHK:
                begin
                    if (rd_t > t_reg)
                        state_reg <= S_LSTART;
                    else
                    begin
                        t0_reg <= rd_t; x0_reg <= rd_x; y0_reg <= rd_y;
                        idx_reg <= idx_reg + 1'b1; state_reg <= S_SCAN;
                    end
                end
                S_LSTART: state_reg <= S_LRUN;
                S_LRUN:
                begin
                    if (xdone && ydone)
                    begin
                        ox_reg <= xres; oy_reg <= yres; state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!ovalid_reg || m_axis_tready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {6'd0, out_st_reg, out_y_reg, out_x_reg};

    `TKI_ASSERT_IMPL(a_count_max, clk, rst_n, 1'b1, count_reg <= CW'(MAX_KNOTS),
        "knot count beyond table size")
    `TKI_ASSERT_IMPL(a_lanes_sync, clk, rst_n, xdone, ydone,
        "interpolation lanes out of step")
    `TKI_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid, "result dropped while stalled")
    `TKI_ASSERT_NEXT(a_out_stable, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        $stable(m_axis_tdata), "result changed while stalled")
endmodule
